// ===== hdl/bba_pkg.sv =====
`default_nettype none

package bba_pkg;

  // bitmap geometry
  localparam int WORD_W            = 64;
  localparam int BIT_W             = 6;
  localparam int BBA_WORDS_DEFAULT = 512;

  // field widths
  localparam int BLK_W  = 32;
  localparam int OP_W   = 2;
  localparam int IDX_W  = 9;
  localparam int STAT_W = 2;
  localparam int CFG_IDX_W = 2;

  // operation codes
  localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
  localparam logic [OP_W-1:0] OP_FREE  = 2'd1;
  localparam logic [OP_W-1:0] OP_LOAD  = 2'd2;

  // result status codes
  localparam logic [STAT_W-1:0] ST_DONE   = 2'd0;
  localparam logic [STAT_W-1:0] ST_FAIL   = 2'd1;
  localparam logic [STAT_W-1:0] ST_IGNORE = 2'd2;
  localparam logic [STAT_W-1:0] ST_LOADED = 2'd3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MOUNTED      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_BLOCK   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DISK_BLOCKS  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_FREE = 2'd3;

  // position of the lowest clear bit; caller guarantees one exists
  function automatic logic [BIT_W-1:0] lowest_clear(input logic [WORD_W-1:0] w);
    logic [BIT_W-1:0] n;
    n = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (!w[i]) n = BIT_W'(i);
    end
    return n;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/bba_store.sv =====
`default_nettype none

module bba_store #(
  parameter int BITMAP_WORDS = bba_pkg::BBA_WORDS_DEFAULT,
  parameter int AW = (BITMAP_WORDS > 1) ? $clog2(BITMAP_WORDS) : 1
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic [AW-1:0]             rd_addr,
  output logic      [bba_pkg::WORD_W-1:0] rd_data,
  input  wire logic                      wr_en,
  input  wire logic [AW-1:0]             wr_addr,
  input  wire logic [bba_pkg::WORD_W-1:0] wr_data,
  output logic                           busy
);
  import bba_pkg::*;

  logic [WORD_W-1:0] mem [BITMAP_WORDS];
  logic [AW-1:0]     clr_addr;

  // clearing pass after reset, one word per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b1;
      clr_addr <= '0;
    end else if (busy) begin
      if (clr_addr == AW'(BITMAP_WORDS - 1)) begin
        busy <= 1'b0;
      end
      clr_addr <= clr_addr + AW'(1);
    end
  end

  // bitmap memory, registered read
  always_ff @(posedge clk) begin
    if (busy) begin
      mem[clr_addr] <= '0;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

// ===== hdl/bitmap_block_allocator.sv =====
`default_nettype none

// First-fit bitmap block allocator. The used-block bitmap lives in a memory of
// BITMAP_WORDS 64-bit words with one registered read port. After reset the
// block clears the bitmap and stalls requests meanwhile; configuration writes
// are taken at any time. A request is handled one at a time: a load writes its
// word if the index is inside the store, a free reads the word, then writes it
// back, and an allocate scans the words from the first, reading one word per
// cycle, up to the first word with a clear bit, then sets its lowest clear bit
// unless that block lies past the end of the disk; a scan that finds every word
// full fails. A failed allocate that sees an unmounted volume or a zero counter
// returns without a scan. The result sits in an output register, so the next
// request is taken while it waits to be drained.
module bitmap_block_allocator #(
  parameter int BITMAP_WORDS = bba_pkg::BBA_WORDS_DEFAULT
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  // configuration
  input  wire logic                         cfg_write,
  input  wire logic [bba_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [bba_pkg::BLK_W-1:0]     cfg_data,
  // request channel
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic [bba_pkg::OP_W-1:0]      operation,
  input  wire logic [bba_pkg::BLK_W-1:0]     block_number,
  input  wire logic [bba_pkg::IDX_W-1:0]     word_index,
  input  wire logic [bba_pkg::WORD_W-1:0]    word_value,
  // result channel
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic      [bba_pkg::STAT_W-1:0]    status,
  output logic      [bba_pkg::BLK_W-1:0]     allocated_block,
  output logic      [bba_pkg::BLK_W-1:0]     free_count
);
  import bba_pkg::*;

  localparam int AW = (BITMAP_WORDS > 1) ? $clog2(BITMAP_WORDS) : 1;

  typedef enum logic [7:0] {
    S_CLEAR  = 8'b0000_0001,
    S_IDLE   = 8'b0000_0010,
    S_DECODE = 8'b0000_0100,
    S_SCAN   = 8'b0000_1000,
    S_FIND   = 8'b0001_0000,
    S_PLACE  = 8'b0010_0000,
    S_FREE   = 8'b0100_0000,
    S_RESP   = 8'b1000_0000
  } state_t;

  state_t state;

  // configuration registers and counter
  logic             mounted;
  logic [BLK_W-1:0] base_block;
  logic [BLK_W-1:0] disk_blocks;
  logic [BLK_W-1:0] free_counter;

  // captured request
  logic [OP_W-1:0]   cur_op;
  logic [BLK_W-1:0]  cur_block;
  logic [IDX_W-1:0]  cur_index;
  logic [WORD_W-1:0] cur_value;

  // scan and modify working registers
  logic [AW-1:0]     word_addr;
  logic [BIT_W-1:0]  bit_idx;
  logic [WORD_W-1:0] hold_word;
  logic [STAT_W-1:0] res_status;
  logic [BLK_W-1:0]  res_block;

  // memory port
  logic [AW-1:0]     rd_addr;
  logic [WORD_W-1:0] rd_data;
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic [WORD_W-1:0] wr_data;
  logic              store_busy;

  // free range check
  logic [BLK_W-1:0] rel_block;
  logic [BLK_W-1:0] rel_word;
  logic             free_ok;

  // load index check
  logic [BLK_W-1:0] load_index;
  logic             load_ok;

  // candidate block of an allocation
  logic [BLK_W:0]   cand_block;
  logic             cand_ok;

  logic             accept;
  logic             out_free;

  bba_store #(
    .BITMAP_WORDS(BITMAP_WORDS),
    .AW          (AW)
  ) u_store (
    .clk    (clk),
    .rst    (rst),
    .rd_addr(rd_addr),
    .rd_data(rd_data),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .busy   (store_busy)
  );

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  // free: mounted, in range and inside the bitmap store
  always_comb begin
    rel_block = cur_block - base_block;
    rel_word  = {6'b0, rel_block[BLK_W-1:BIT_W]};
    free_ok   = mounted && (cur_block >= base_block) && (cur_block < disk_blocks)
                && (rel_word < BLK_W'(BITMAP_WORDS));
  end

  // load: index inside the bitmap store
  always_comb begin
    load_index = {{(BLK_W - IDX_W){1'b0}}, cur_index};
    load_ok    = load_index < BLK_W'(BITMAP_WORDS);
  end

  // allocation candidate and disk bound
  always_comb begin
    cand_block = {1'b0, base_block} + (BLK_W + 1)'({word_addr, bit_idx});
    cand_ok    = cand_block < {1'b0, disk_blocks};
  end

  // memory read address, load write and write-back
  always_comb begin
    rd_addr = word_addr + AW'(1);
    wr_en   = 1'b0;
    wr_addr = word_addr;
    wr_data = hold_word;
    case (state)
      S_DECODE: begin
        if (cur_op == OP_ALLOC) begin
          rd_addr = '0;
        end else begin
          rd_addr = rel_block[AW+BIT_W-1:BIT_W];
        end
        if (cur_op == OP_LOAD && load_ok) begin
          wr_en   = 1'b1;
          wr_addr = load_index[AW-1:0];
          wr_data = cur_value;
        end
      end
      S_PLACE: begin
        wr_en   = cand_ok;
        wr_data = hold_word | (WORD_W'(1) << bit_idx);
      end
      S_FREE: begin
        wr_en   = 1'b1;
        wr_data = rd_data & ~(WORD_W'(1) << bit_idx);
      end
      default: begin
      end
    endcase
  end

  // control, counter and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      mounted      <= 1'b0;
      base_block   <= '0;
      disk_blocks  <= '0;
      free_counter <= '0;
      out_valid    <= 1'b0;
    end else begin
      // result register handshake
      if (state == S_RESP && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      if (cfg_write) begin
        case (cfg_index)
          CFG_MOUNTED:      mounted      <= cfg_data[0];
          CFG_BASE_BLOCK:   base_block   <= cfg_data;
          CFG_DISK_BLOCKS:  disk_blocks  <= cfg_data;
          CFG_INITIAL_FREE: free_counter <= cfg_data;
          default: begin
          end
        endcase
      end

      case (state)
        S_CLEAR: begin
          if (!store_busy) state <= S_IDLE;
        end
        S_IDLE: begin
          if (accept) state <= S_DECODE;
        end
        S_DECODE: begin
          res_block <= '0;
          case (cur_op)
            OP_ALLOC: begin
              if (mounted && free_counter != '0) begin
                word_addr <= '0;
                state     <= S_SCAN;
              end else begin
                res_status <= ST_FAIL;
                state      <= S_RESP;
              end
            end
            OP_FREE: begin
              if (free_ok) begin
                word_addr <= rel_block[AW+BIT_W-1:BIT_W];
                bit_idx   <= rel_block[BIT_W-1:0];
                state     <= S_FREE;
              end else begin
                res_status <= ST_IGNORE;
                state      <= S_RESP;
              end
            end
            OP_LOAD: begin
              res_status <= ST_LOADED;
              state      <= S_RESP;
            end
            default: begin
              res_status <= ST_DONE;
              state      <= S_RESP;
            end
          endcase
        end
        S_SCAN: begin
          // rd_data holds the word at word_addr
          if (rd_data != '1) begin
            hold_word <= rd_data;
            state     <= S_FIND;
          end else if (word_addr == AW'(BITMAP_WORDS - 1)) begin
            res_status <= ST_FAIL;
            state      <= S_RESP;
          end else begin
            word_addr <= word_addr + AW'(1);
          end
        end
        S_FIND: begin
          bit_idx <= lowest_clear(hold_word);
          state   <= S_PLACE;
        end
        S_PLACE: begin
          if (cand_ok) begin
            free_counter <= free_counter - BLK_W'(1);
            res_status   <= ST_DONE;
            res_block    <= cand_block[BLK_W-1:0];
          end else begin
            res_status <= ST_FAIL;
          end
          state <= S_RESP;
        end
        S_FREE: begin
          free_counter <= free_counter + BLK_W'(1);
          res_status   <= ST_DONE;
          state        <= S_RESP;
        end
        S_RESP: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_CLEAR;
      endcase
    end
  end

  // request capture and result register
  always_ff @(posedge clk) begin
    if (accept) begin
      cur_op    <= operation;
      cur_block <= block_number;
      cur_index <= word_index;
      cur_value <= word_value;
    end
    if (state == S_RESP && out_free) begin
      status          <= res_status;
      allocated_block <= res_block;
      free_count      <= free_counter;
    end
  end

endmodule

`default_nettype wire

// ===== bench/tb_bitmap_block_allocator.sv =====
`timescale 1ns / 1ps

module tb_bitmap_block_allocator;
  import bba_pkg::*;

  localparam int MAP_WORDS = BBA_WORDS_DEFAULT;
  localparam int QUIET_LIMIT = 5000;
  localparam int RANDOM_PHASES = 11;
  localparam int PHASE_REQUESTS = 115;
  localparam int SQUEEZE_PHASE = 2;
  localparam int SQUEEZE_CYCLES = 300;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [BLK_W-1:0]  blk;
    logic [IDX_W-1:0]  idx;
    logic [WORD_W-1:0] value;
  } request_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [BLK_W-1:0]  block;
    logic [BLK_W-1:0]  count;
  } outcome_t;

  typedef enum logic {STEP_REQ, STEP_CFG} step_kind_t;

  typedef struct packed {
    step_kind_t             kind;
    request_t               req;
    logic [CFG_IDX_W-1:0]   cfg_idx;
    logic [BLK_W-1:0]       cfg_val;
    logic                   typed;
    outcome_t               want;
  } plan_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [BLK_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [OP_W-1:0] operation = '0;
  logic [BLK_W-1:0] block_number = '0;
  logic [IDX_W-1:0] word_index = '0;
  logic [WORD_W-1:0] word_value = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [STAT_W-1:0] status;
  logic [BLK_W-1:0] allocated_block;
  logic [BLK_W-1:0] free_count;

  // shadow copy of the allocator state and settings
  logic [WORD_W-1:0] shadow_map [MAP_WORDS];
  logic [BLK_W-1:0] shadow_free;
  logic set_mounted;
  logic [BLK_W-1:0] set_base;
  logic [BLK_W-1:0] set_total;

  outcome_t pending_outcomes[$];
  plan_t directed_plan[$];
  int mismatches = 0;
  int results_seen = 0;
  int quiet_cycles = 0;
  bit sender_steady = 1'b0;
  bit squeeze_go = 1'b0;

  bitmap_block_allocator dut (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .operation(operation),
    .block_number(block_number),
    .word_index(word_index),
    .word_value(word_value),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .status(status),
    .allocated_block(allocated_block),
    .free_count(free_count)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // first-fit allocation, free and word load on the shadow state
  function automatic outcome_t apply_request(input request_t r);
    outcome_t o;
    int w;
    int b;
    logic [33:0] reach;
    logic [BLK_W-1:0] rel;
    o.status = ST_DONE;
    o.block = '0;
    case (r.op)
      OP_ALLOC: begin
        o.status = ST_FAIL;
        if (set_mounted && shadow_free != '0) begin
          w = 0;
          while (w < MAP_WORDS && shadow_map[w] == '1) w++;
          if (w < MAP_WORDS) begin
            b = 0;
            while (shadow_map[w][b]) b++;
            reach = 34'(set_base) + 34'(w * WORD_W + b);
            // bit past the end of the disk stays clear
            if (reach < 34'(set_total)) begin
              shadow_map[w][b] = 1'b1;
              shadow_free = shadow_free - 32'd1;
              o.block = reach[BLK_W-1:0];
              o.status = ST_DONE;
            end
          end
        end
      end
      OP_FREE: begin
        o.status = ST_IGNORE;
        if (set_mounted && r.blk >= set_base && r.blk < set_total) begin
          rel = r.blk - set_base;
          if (rel[BLK_W-1:BIT_W] < MAP_WORDS) begin
            // already free blocks still bump the counter
            shadow_map[rel[BLK_W-1:BIT_W]][rel[BIT_W-1:0]] = 1'b0;
            shadow_free = shadow_free + 32'd1;
            o.status = ST_DONE;
          end
        end
      end
      OP_LOAD: begin
        if (r.idx < MAP_WORDS) shadow_map[r.idx] = r.value;
        o.status = ST_LOADED;
      end
      default: o.status = ST_DONE;
    endcase
    o.count = shadow_free;
    return o;
  endfunction

  function automatic void note_setting(input logic [CFG_IDX_W-1:0] idx,
                                       input logic [BLK_W-1:0] val);
    case (idx)
      CFG_MOUNTED:      set_mounted = val[0];
      CFG_BASE_BLOCK:   set_base = val;
      CFG_DISK_BLOCKS:  set_total = val;
      CFG_INITIAL_FREE: shadow_free = val;
      default: ;
    endcase
  endfunction

  function automatic plan_t req_step(input logic [OP_W-1:0] op, input logic [BLK_W-1:0] blk,
                                     input logic [IDX_W-1:0] idx,
                                     input logic [WORD_W-1:0] val);
    plan_t s;
    s = '0;
    s.kind = STEP_REQ;
    s.req.op = op;
    s.req.blk = blk;
    s.req.idx = idx;
    s.req.value = val;
    return s;
  endfunction

  function automatic plan_t cfg_step(input logic [CFG_IDX_W-1:0] idx,
                                     input logic [BLK_W-1:0] val);
    plan_t s;
    s = '0;
    s.kind = STEP_CFG;
    s.cfg_idx = idx;
    s.cfg_val = val;
    return s;
  endfunction

  function automatic plan_t with_result(input plan_t s, input logic [STAT_W-1:0] st,
                                        input logic [BLK_W-1:0] blk,
                                        input logic [BLK_W-1:0] cnt);
    s.typed = 1'b1;
    s.want.status = st;
    s.want.block = blk;
    s.want.count = cnt;
    return s;
  endfunction

  // idle cycles before the next request, mostly short
  function automatic int sender_gap();
    int pick;
    if (sender_steady) return 0;
    pick = $urandom_range(0, 99);
    if (pick < 55) return 0;
    if (pick < 85) return $urandom_range(1, 3);
    if (pick < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // offer one request, predict its result once it is taken
  task automatic offer_request(input request_t r, input logic typed, input outcome_t want);
    int gap;
    outcome_t predicted;
    gap = sender_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    operation <= r.op;
    block_number <= r.blk;
    word_index <= r.idx;
    word_value <= r.value;
    do @(posedge clk); while (in_stall);
    predicted = apply_request(r);
    pending_outcomes.push_back(typed ? want : predicted);
  endtask

  task automatic write_setting(input logic [CFG_IDX_W-1:0] idx, input logic [BLK_W-1:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    note_setting(idx, val);
  endtask

  // let the block run dry before touching the settings
  task automatic drain_outcomes();
    in_valid <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // result checker
  always @(posedge clk) begin
    outcome_t want;
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      if (pending_outcomes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result %0d: none expected, got status %0d block %h count %h",
                   results_seen, status, allocated_block, free_count);
      end else begin
        want = pending_outcomes.pop_front();
        if (status !== want.status || allocated_block !== want.block ||
            free_count !== want.count) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"result %0d: status exp %0d got %0d, block exp %h got %h, ",
                      "count exp %h got %h"}, results_seen, want.status, status,
                     want.block, allocated_block, want.count, free_count);
        end
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst || cfg_write || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("** bitmap_block_allocator: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // result side stalls, with one long hold-off on request
  initial begin : result_pacing
    int hold;
    int run;
    bit held;
    held = 1'b0;
    @(posedge clk);
    forever begin
      if (squeeze_go && !held) begin
        held = 1'b1;
        out_stall <= 1'b1;
        repeat (SQUEEZE_CYCLES) @(posedge clk);
      end
      hold = $urandom_range(0, 99);
      if (hold < 50) hold = 0;
      else if (hold < 85) hold = $urandom_range(1, 3);
      else if (hold < 97) hold = $urandom_range(4, 15);
      else hold = $urandom_range(30, 80);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      run = ($urandom_range(0, 9) < 3) ? $urandom_range(40, 200) : $urandom_range(1, 6);
      repeat (run) @(posedge clk);
    end
  end

  // stimulus
  initial begin : stimulus
    request_t r;
    plan_t s;
    logic cfg_open;
    logic [BLK_W-1:0] ds;
    logic [BLK_W-1:0] total;
    logic [BLK_W-1:0] init;
    logic [32:0] sum;
    int ph;
    int k;

    for (k = 0; k < MAP_WORDS; k++) shadow_map[k] = '0;
    set_mounted = 1'b0;
    set_base = '0;
    set_total = '0;
    shadow_free = '0;

    // unmounted after reset, all settings zero
    directed_plan.push_back(with_result(req_step(OP_ALLOC, '0, '0, '0), ST_FAIL, '0, '0));
    directed_plan.push_back(with_result(req_step(OP_FREE, '0, '0, '0), ST_IGNORE, '0, '0));
    directed_plan.push_back(with_result(req_step(OP_UNUSED, '1, '1, '1), ST_DONE, '0, '0));
    directed_plan.push_back(with_result(req_step(OP_LOAD, '0, '1, '0), ST_LOADED, '0, '0));
    // mounted volume, data starting at block 100, store fully on disk
    directed_plan.push_back(cfg_step(CFG_MOUNTED, 32'd1));
    directed_plan.push_back(cfg_step(CFG_BASE_BLOCK, 32'd100));
    directed_plan.push_back(cfg_step(CFG_DISK_BLOCKS, 32'd100 + 32'(MAP_WORDS * WORD_W)));
    directed_plan.push_back(cfg_step(CFG_INITIAL_FREE, 32'd5));
    directed_plan.push_back(with_result(req_step(OP_ALLOC, '0, '0, '0), ST_DONE, 32'd100, 32'd4));
    directed_plan.push_back(with_result(req_step(OP_ALLOC, '0, '0, '0), ST_DONE, 32'd101, 32'd3));
    directed_plan.push_back(with_result(req_step(OP_FREE, 32'd100, '0, '0), ST_DONE, '0, 32'd4));
    // freeing an already free block still counts
    directed_plan.push_back(with_result(req_step(OP_FREE, 32'd100, '0, '0), ST_DONE, '0, 32'd5));
    directed_plan.push_back(with_result(req_step(OP_FREE, 32'd99, '0, '0), ST_IGNORE, '0, 32'd5));
    directed_plan.push_back(with_result(req_step(OP_FREE, 32'd100 + 32'(MAP_WORDS * WORD_W),
                                                 '0, '0), ST_IGNORE, '0, 32'd5));
    directed_plan.push_back(with_result(req_step(OP_FREE, '1, '0, '0), ST_IGNORE, '0, 32'd5));
    directed_plan.push_back(with_result(req_step(OP_LOAD, '0, '0, '1), ST_LOADED, '0, 32'd5));
    directed_plan.push_back(req_step(OP_ALLOC, '0, '0, '0));
    // only the top bit of word zero clear
    directed_plan.push_back(req_step(OP_LOAD, '0, '0, 64'h7FFF_FFFF_FFFF_FFFF));
    directed_plan.push_back(req_step(OP_ALLOC, '0, '0, '0));
    // empty counter
    directed_plan.push_back(cfg_step(CFG_INITIAL_FREE, '0));
    directed_plan.push_back(with_result(req_step(OP_ALLOC, '0, '0, '0), ST_FAIL, '0, '0));
    directed_plan.push_back(req_step(OP_FREE, 32'd163, '0, '0));
    // counter wraps to zero on free
    directed_plan.push_back(cfg_step(CFG_INITIAL_FREE, '1));
    directed_plan.push_back(with_result(req_step(OP_FREE, 32'd164, '0, '0), ST_DONE, '0, '0));
    directed_plan.push_back(with_result(req_step(OP_ALLOC, '0, '0, '0), ST_FAIL, '0, '0));
    // first clear bit lies past the end of the disk
    directed_plan.push_back(cfg_step(CFG_INITIAL_FREE, 32'd10));
    directed_plan.push_back(cfg_step(CFG_DISK_BLOCKS, 32'd163));
    directed_plan.push_back(req_step(OP_ALLOC, '0, '0, '0));
    // block beyond the bitmap store, then the last bit of the store
    directed_plan.push_back(cfg_step(CFG_BASE_BLOCK, '0));
    directed_plan.push_back(cfg_step(CFG_DISK_BLOCKS, '1));
    directed_plan.push_back(with_result(req_step(OP_FREE, 32'(MAP_WORDS * WORD_W), '0, '0),
                                        ST_IGNORE, '0, 32'd10));
    directed_plan.push_back(with_result(req_step(OP_FREE, 32'(MAP_WORDS * WORD_W - 1), '0, '0),
                                        ST_DONE, '0, 32'd11));
    // block numbers near the top of the 32-bit range
    directed_plan.push_back(cfg_step(CFG_BASE_BLOCK, 32'hFFFF_FFC0));
    directed_plan.push_back(req_step(OP_ALLOC, '0, '0, '0));
    directed_plan.push_back(cfg_step(CFG_BASE_BLOCK, 32'hFFFF_FF00));
    directed_plan.push_back(req_step(OP_ALLOC, '0, '0, '0));
    directed_plan.push_back(cfg_step(CFG_MOUNTED, '0));
    directed_plan.push_back(req_step(OP_FREE, 32'hFFFF_FF3F, '0, '0));

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed walk
    cfg_open = 1'b0;
    foreach (directed_plan[i]) begin
      s = directed_plan[i];
      if (s.kind == STEP_CFG) begin
        if (!cfg_open) drain_outcomes();
        write_setting(s.cfg_idx, s.cfg_val);
        cfg_open = 1'b1;
      end else begin
        if (cfg_open) begin
          cfg_write <= 1'b0;
          cfg_open = 1'b0;
        end
        offer_request(s.req, s.typed, s.want);
      end
    end

    // random phases, each under fresh settings
    for (ph = 0; ph < RANDOM_PHASES; ph++) begin
      drain_outcomes();
      case ($urandom_range(0, 4))
        0: ds = '0;
        1: ds = 32'($urandom_range(1, 5000));
        2: ds = $urandom;
        3: ds = 32'hFFFF_FFFF - 32'($urandom_range(0, 40000));
        default: ds = '1;
      endcase
      case ($urandom_range(0, 7))
        0, 1, 2: begin
          sum = 33'(ds) + 33'($urandom_range(0, 3000));
          total = sum[32] ? '1 : sum[BLK_W-1:0];
        end
        3: total = '1;
        4: total = '0;
        5: total = $urandom;
        default: begin
          sum = 33'(ds) + 33'(MAP_WORDS * WORD_W);
          total = sum[32] ? '1 : sum[BLK_W-1:0];
        end
      endcase
      case ($urandom_range(0, 5))
        0: init = '0;
        1: init = '1;
        2: init = $urandom;
        default: init = 32'($urandom_range(1, 4000));
      endcase
      // one phase runs unmounted; upper bits of the mount word are don't-care
      write_setting(CFG_MOUNTED, {31'($urandom), 1'(ph != 4)});
      write_setting(CFG_BASE_BLOCK, ds);
      write_setting(CFG_DISK_BLOCKS, total);
      write_setting(CFG_INITIAL_FREE, init);
      cfg_write <= 1'b0;
      sender_steady = (ph == SQUEEZE_PHASE) || ($urandom_range(0, 3) == 0);

      for (k = 0; k < PHASE_REQUESTS; k++) begin
        if (ph == SQUEEZE_PHASE && k == 30) squeeze_go = 1'b1;
        r.op = OP_ALLOC;
        r.blk = $urandom;
        r.idx = 9'($urandom);
        r.value = {$urandom, $urandom};
        case ($urandom_range(0, 19))
          0, 1, 2, 3, 4, 5, 6, 7: r.op = OP_ALLOC;
          8, 9, 10, 11, 12, 13, 14: begin
            r.op = OP_FREE;
            case ($urandom_range(0, 9))
              0, 1, 2, 3, 4, 5: r.blk = set_base + 32'($urandom_range(0, 600));
              6: case ($urandom_range(0, 3))
                0: r.blk = set_base - 32'd1;
                1: r.blk = set_total - 32'd1;
                2: r.blk = set_total;
                default: r.blk = set_base + 32'(MAP_WORDS * WORD_W - 1)
                                 + 32'($urandom_range(0, 1));
              endcase
              default: ;
            endcase
          end
          15, 16, 17, 18: begin
            r.op = OP_LOAD;
            if ($urandom_range(0, 9) < 6) r.idx = 9'($urandom_range(0, 7));
            case ($urandom_range(0, 3))
              0: r.value = '0;
              1: r.value = '1;
              2: r.value = ~(64'd1 << $urandom_range(0, WORD_W - 1));
              default: ;
            endcase
          end
          default: r.op = OP_UNUSED;
        endcase
        offer_request(r, 1'b0, '0);
      end
    end

    // whole bitmap full, then frees, word loads and allocations that scan it
    drain_outcomes();
    write_setting(CFG_MOUNTED, 32'd1);
    write_setting(CFG_BASE_BLOCK, 32'($urandom_range(0, 1000)));
    write_setting(CFG_DISK_BLOCKS, '1);
    write_setting(CFG_INITIAL_FREE, 32'($urandom_range(50, 500)));
    cfg_write <= 1'b0;
    sender_steady = 1'b0;
    for (k = 0; k < MAP_WORDS; k++) begin
      r.op = OP_LOAD;
      r.blk = $urandom;
      r.idx = 9'(k);
      r.value = '1;
      offer_request(r, 1'b0, '0);
    end
    for (k = 0; k < 64; k++) begin
      r.op = OP_ALLOC;
      r.blk = $urandom;
      r.idx = 9'($urandom);
      r.value = '1;
      if (k >= 4) begin
        case ($urandom_range(0, 19))
          0, 1, 2, 3, 4, 5, 6: begin
            r.op = OP_FREE;
            r.blk = set_base + 32'($urandom_range(0, MAP_WORDS * WORD_W - 1));
          end
          7, 8, 9, 10, 11, 12, 13, 14: r.op = OP_ALLOC;
          15, 16, 17: begin
            r.op = OP_LOAD;
            r.value = ~(64'd1 << $urandom_range(0, WORD_W - 1));
          end
          default: r.op = OP_FREE;
        endcase
      end
      offer_request(r, 1'b0, '0);
    end

    // wind down
    in_valid <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (mismatches == 0) begin
      $display("** bitmap_block_allocator: PASSED **");
    end else begin
      $display("** bitmap_block_allocator: FAILED **");
    end
    $finish;
  end

endmodule
